>>> rtl/core/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg - calendar clock advance shared definitions
// request and result types, controller commands, calendar constants and
// the small calendar functions used by the datapath and the divider
// ----------------------------------------------------------------------------
package cca_pkg;

    // calendar constants
    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int MON_PER_YEAR  = 12;
    localparam int LEAP_STEP     = 4;
    localparam int CENTURY       = 100;
    localparam int YEAR_CYCLE    = 400;
    localparam int DAYS_FEB      = 28;
    localparam int DAYS_FEB_LEAP = 29;
    localparam int DAYS_SHORT    = 30;
    localparam int DAYS_LONG     = 31;
    localparam int DAYS_PER_WEEK = 7;
    localparam int YEAR_MAX      = 65535;

    // zero-based month numbers that matter for month length
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_NOV = 4'd10;

    // days before each month in a common year
    localparam logic [8:0] CUM_DAYS [MON_PER_YEAR] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // constant divider by reciprocal multiplication
    localparam int NUM_W    = 17;
    localparam int QUO_W    = 11;
    localparam int REM_W    = 9;
    localparam int RECIP_W  = 14;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam int DIV_SHIFT = NUM_W;
    localparam int RECIP_60  = (1 << DIV_SHIFT) / SEC_PER_MIN;
    localparam int RECIP_24  = (1 << DIV_SHIFT) / HOUR_PER_DAY;
    localparam int RECIP_12  = (1 << DIV_SHIFT) / MON_PER_YEAR;
    localparam int RECIP_400 = (1 << DIV_SHIFT) / YEAR_CYCLE;

    // request payload
    typedef struct packed {
        logic        kind;
        logic [15:0] year_value;
        logic [7:0]  month_value;
        logic [15:0] day_value;
        logic [7:0]  hour_value;
        logic [7:0]  minute_value;
        logic [15:0] second_value;
    } t_in;

    // result payload
    typedef struct packed {
        logic [15:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  weekday;
        logic        leap;
        logic [1:0]  error;
    } t_out;

    // error codes
    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_SET  = 2'd1,
        ERR_YEAR = 2'd2
    } t_err;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MUL    = 4'd2,
        OP_FIX    = 4'd3,
        OP_YCHK   = 4'd4,
        OP_DAY    = 4'd5,
        OP_COMMIT = 4'd6,
        OP_WEEK   = 4'd7,
        OP_OUT    = 4'd8
    } t_op;

    // field handled by the shared divider
    typedef enum logic [2:0] {
        SEL_SEC  = 3'd0,
        SEL_MIN  = 3'd1,
        SEL_HOUR = 3'd2,
        SEL_MON  = 3'd3,
        SEL_YEAR = 3'd4
    } t_sel;

    typedef struct packed {
        t_op  op;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic err_flag;
        logic year_ovf;
        logic day_done;
    } t_sts;

    // divisor of each field
    function automatic logic [REM_W-1:0] sel_divisor(input t_sel sel);
        logic [REM_W-1:0] d;
        case (sel)
            SEL_SEC:  d = REM_W'(SEC_PER_MIN);
            SEL_MIN:  d = REM_W'(MIN_PER_HOUR);
            SEL_HOUR: d = REM_W'(HOUR_PER_DAY);
            SEL_MON:  d = REM_W'(MON_PER_YEAR);
            SEL_YEAR: d = REM_W'(YEAR_CYCLE);
            default:  d = REM_W'(YEAR_CYCLE);
        endcase
        return d;
    endfunction

    // scaled reciprocal of each divisor, rounded down
    function automatic logic [RECIP_W-1:0] sel_recip(input t_sel sel);
        logic [RECIP_W-1:0] k;
        case (sel)
            SEL_SEC:  k = RECIP_W'(RECIP_60);
            SEL_MIN:  k = RECIP_W'(RECIP_60);
            SEL_HOUR: k = RECIP_W'(RECIP_24);
            SEL_MON:  k = RECIP_W'(RECIP_12);
            SEL_YEAR: k = RECIP_W'(RECIP_400);
            default:  k = RECIP_W'(RECIP_400);
        endcase
        return k;
    endfunction

    // leap year from the year modulo 400
    function automatic logic leap_of400(input logic [8:0] r);
        return (r[1:0] == 2'd0) &&
               !(r == 9'(CENTURY) || r == 9'(2 * CENTURY) || r == 9'(3 * CENTURY));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        if (m == MON_FEB) begin
            len = lp ? 5'(DAYS_FEB_LEAP) : 5'(DAYS_FEB);
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'(DAYS_SHORT);
        end else begin
            len = 5'(DAYS_LONG);
        end
        return len;
    endfunction

    // days in the year before the given month
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic lp);
        logic [8:0] c;
        if (m > 4'(MON_PER_YEAR - 1)) begin
            c = '0;
        end else begin
            c = CUM_DAYS[m] + ((lp && m > MON_FEB) ? 9'd1 : 9'd0);
        end
        return c;
    endfunction

    // modulo 7 by folding octal digits, since 8 is 1 modulo 7
    function automatic logic [2:0] mod7(input logic [11:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        if (b >= 4'(DAYS_PER_WEEK)) begin
            b = b - 4'(DAYS_PER_WEEK);
        end
        return b[2:0];
    endfunction

endpackage

>>> rtl/core/cca_cdiv.sv
// ----------------------------------------------------------------------------
// cca_cdiv - shared divider by a constant
// divides a field sum by 60, 24, 12 or 400: a registered
// reciprocal product, then one compare and subtract correction
// ----------------------------------------------------------------------------
module cca_cdiv (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [cca_pkg::NUM_W-1:0]   i_num,
    input  cca_pkg::t_sel               i_sel,
    output logic [cca_pkg::QUO_W-1:0]   o_quo,
    output logic [cca_pkg::REM_W-1:0]   o_rem
);

    logic [cca_pkg::NUM_W-1:0]  r_num;
    logic [cca_pkg::PROD_W-1:0] r_prod;
    logic [cca_pkg::REM_W-1:0]  r_dvsr;
    logic [cca_pkg::QUO_W-1:0]  q_est;
    logic [cca_pkg::NUM_W-1:0]  rem_est;

    // reciprocal product stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num  <= i_num;
            r_prod <= cca_pkg::PROD_W'(i_num)
                      * cca_pkg::PROD_W'(cca_pkg::sel_recip(i_sel));
            r_dvsr <= cca_pkg::sel_divisor(i_sel);
        end
    end

    // estimate is exact or one low, fix with one compare
    always_comb begin
        q_est   = r_prod[cca_pkg::DIV_SHIFT +: cca_pkg::QUO_W];
        rem_est = r_num - cca_pkg::NUM_W'(q_est) * cca_pkg::NUM_W'(r_dvsr);
        if (rem_est >= cca_pkg::NUM_W'(r_dvsr)) begin
            o_quo = q_est + cca_pkg::QUO_W'(1);
            o_rem = cca_pkg::REM_W'(rem_est - cca_pkg::NUM_W'(r_dvsr));
        end else begin
            o_quo = q_est;
            o_rem = cca_pkg::REM_W'(rem_est);
        end
    end

endmodule

>>> rtl/core/cca_datapath.sv
// ----------------------------------------------------------------------------
// cca_datapath - calendar clock datapath
// request latch, working fields, month-by-month day carry, committed date
// and time, weekday computation and the result register
// ----------------------------------------------------------------------------
module cca_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cca_pkg::t_cmd  i_cmd,
    input  cca_pkg::t_in   i_in_data,
    output cca_pkg::t_sts  o_sts,
    output cca_pkg::t_out  o_out_data
);

    cca_pkg::t_in  r_in;
    cca_pkg::t_err r_err;
    cca_pkg::t_out r_out;

    // working fields of an advance
    logic [10:0] r_q;
    logic [17:0] r_wy;
    logic [16:0] r_wd;
    logic [3:0]  r_wm;
    logic [4:0]  r_wh;
    logic [5:0]  r_wn;
    logic [5:0]  r_ws;
    logic [8:0]  r_w400;

    // committed date and time
    logic [15:0] r_cy;
    logic [3:0]  r_cm;
    logic [4:0]  r_cd;
    logic [4:0]  r_ch;
    logic [5:0]  r_cn;
    logic [5:0]  r_cs;
    logic [8:0]  r_c400;

    // weekday pieces
    logic [2:0]  r_jan1;
    logic [8:0]  r_diy;

    logic [cca_pkg::NUM_W-1:0] div_num;
    logic [cca_pkg::QUO_W-1:0] div_quo;
    logic [cca_pkg::REM_W-1:0] div_rem;
    logic [4:0]  work_len;
    logic        day_done;
    logic [4:0]  set_len;
    logic        set_bad;
    logic        c_leap;
    logic [8:0]  p400;
    logic [6:0]  p100;
    logic [11:0] jan1_sum;

    // dividend of the field being divided
    always_comb begin
        case (i_cmd.sel)
            cca_pkg::SEL_SEC:  div_num = 17'(r_cs) + 17'(r_in.second_value);
            cca_pkg::SEL_MIN:  div_num = 17'(r_cn) + 17'(r_in.minute_value) + 17'(r_q);
            cca_pkg::SEL_HOUR: div_num = 17'(r_ch) + 17'(r_in.hour_value) + 17'(r_q);
            cca_pkg::SEL_MON:  div_num = 17'(r_cm) + 17'(r_in.month_value);
            cca_pkg::SEL_YEAR: div_num = r_in.kind ? 17'(r_wy) : 17'(r_in.year_value);
            default:           div_num = '0;
        endcase
    end

    cca_cdiv u_cdiv (
        .i_clk  (i_clk),
        .i_load (i_cmd.op == cca_pkg::OP_MUL),
        .i_num  (div_num),
        .i_sel  (i_cmd.sel),
        .o_quo  (div_quo),
        .o_rem  (div_rem)
    );

    // month length checks for the day carry and the set range test
    always_comb begin
        work_len = cca_pkg::month_len(r_wm, cca_pkg::leap_of400(r_w400));
        day_done = r_wd < 17'(work_len);
        set_len  = cca_pkg::month_len(r_in.month_value[3:0], cca_pkg::leap_of400(r_w400));
        set_bad  = (r_in.year_value == 16'd0)
                || (r_in.month_value > 8'(cca_pkg::MON_PER_YEAR - 1))
                || (r_in.day_value >= 16'(set_len))
                || (r_in.hour_value > 8'(cca_pkg::HOUR_PER_DAY - 1))
                || (r_in.minute_value > 8'(cca_pkg::MIN_PER_HOUR - 1))
                || (r_in.second_value > 16'(cca_pkg::SEC_PER_MIN - 1));
    end

    // jan 1 weekday terms from the previous year modulo 400
    always_comb begin
        c_leap = cca_pkg::leap_of400(r_c400);
        p400   = (r_c400 == 9'd0) ? 9'(cca_pkg::YEAR_CYCLE - 1) : r_c400 - 9'd1;
        if (p400 >= 9'(3 * cca_pkg::CENTURY)) begin
            p100 = 7'(p400 - 9'(3 * cca_pkg::CENTURY));
        end else if (p400 >= 9'(2 * cca_pkg::CENTURY)) begin
            p100 = 7'(p400 - 9'(2 * cca_pkg::CENTURY));
        end else if (p400 >= 9'(cca_pkg::CENTURY)) begin
            p100 = 7'(p400 - 9'(cca_pkg::CENTURY));
        end else begin
            p100 = 7'(p400);
        end
        jan1_sum = 12'd1 + 12'(p400[1:0]) * 12'd5 + 12'(p100) * 12'd4
                 + 12'(p400) * 12'd6;
    end

    // request latch, working fields and carries
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cca_pkg::OP_LOAD: begin
                r_in  <= i_in_data;
                r_err <= cca_pkg::ERR_OK;
            end
            cca_pkg::OP_FIX: begin
                case (i_cmd.sel)
                    cca_pkg::SEL_SEC: begin
                        r_ws <= div_rem[5:0];
                        r_q  <= div_quo;
                    end
                    cca_pkg::SEL_MIN: begin
                        r_wn <= div_rem[5:0];
                        r_q  <= div_quo;
                    end
                    cca_pkg::SEL_HOUR: begin
                        r_wh <= div_rem[4:0];
                        r_wd <= 17'(r_cd) + 17'(r_in.day_value) + 17'(div_quo);
                    end
                    cca_pkg::SEL_MON: begin
                        r_wm <= div_rem[3:0];
                        r_wy <= 18'(r_cy) + 18'(r_in.year_value) + 18'(div_quo);
                    end
                    cca_pkg::SEL_YEAR: begin
                        r_w400 <= div_rem;
                    end
                    default: begin
                        r_q <= r_q;
                    end
                endcase
            end
            cca_pkg::OP_YCHK: begin
                if (r_wy[17:16] != 2'd0) begin
                    r_err <= cca_pkg::ERR_YEAR;
                end
            end
            cca_pkg::OP_DAY: begin
                // one month of day carry per cycle
                if (r_err == cca_pkg::ERR_OK && !day_done) begin
                    r_wd <= r_wd - 17'(work_len);
                    if (r_wm == 4'(cca_pkg::MON_PER_YEAR - 1)) begin
                        r_wm <= 4'd0;
                        if (r_wy == 18'(cca_pkg::YEAR_MAX)) begin
                            r_err <= cca_pkg::ERR_YEAR;
                        end else begin
                            r_wy   <= r_wy + 18'd1;
                            r_w400 <= (r_w400 == 9'(cca_pkg::YEAR_CYCLE - 1))
                                      ? 9'd0 : r_w400 + 9'd1;
                        end
                    end else begin
                        r_wm <= r_wm + 4'd1;
                    end
                end
            end
            cca_pkg::OP_COMMIT: begin
                if (!r_in.kind && set_bad) begin
                    r_err <= cca_pkg::ERR_SET;
                end
            end
            default: begin
                r_err <= r_err;
            end
        endcase
    end

    // committed date and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy   <= 16'd1;
            r_cm   <= '0;
            r_cd   <= '0;
            r_ch   <= '0;
            r_cn   <= '0;
            r_cs   <= '0;
            r_c400 <= 9'd1;
        end else if (i_cmd.op == cca_pkg::OP_COMMIT) begin
            if (!r_in.kind) begin
                if (!set_bad) begin
                    r_cy   <= r_in.year_value;
                    r_cm   <= r_in.month_value[3:0];
                    r_cd   <= r_in.day_value[4:0];
                    r_ch   <= r_in.hour_value[4:0];
                    r_cn   <= r_in.minute_value[5:0];
                    r_cs   <= r_in.second_value[5:0];
                    r_c400 <= r_w400;
                end
            end else if (r_err == cca_pkg::ERR_OK) begin
                r_cy   <= r_wy[15:0];
                r_cm   <= r_wm;
                r_cd   <= r_wd[4:0];
                r_ch   <= r_wh;
                r_cn   <= r_wn;
                r_cs   <= r_ws;
                r_c400 <= r_w400;
            end
        end
    end

    // weekday pieces and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cca_pkg::OP_WEEK) begin
            r_jan1 <= cca_pkg::mod7(jan1_sum);
            r_diy  <= cca_pkg::cum_days(r_cm, c_leap) + 9'(r_cd);
        end
        if (i_cmd.op == cca_pkg::OP_OUT) begin
            r_out.cur_year   <= r_cy;
            r_out.cur_month  <= r_cm;
            r_out.cur_day    <= r_cd;
            r_out.cur_hour   <= r_ch;
            r_out.cur_minute <= r_cn;
            r_out.cur_second <= r_cs;
            r_out.weekday    <= cca_pkg::mod7(12'(r_diy) + 12'(r_jan1));
            r_out.leap       <= c_leap;
            r_out.error      <= r_err;
        end
    end

    assign o_sts.kind     = r_in.kind;
    assign o_sts.err_flag = (r_err != cca_pkg::ERR_OK);
    assign o_sts.year_ovf = (r_wy[17:16] != 2'd0);
    assign o_sts.day_done = day_done;
    assign o_out_data     = r_out;

endmodule

>>> rtl/core/cca_ctrl.sv
// ----------------------------------------------------------------------------
// cca_ctrl - calendar clock controller
// sequences one request through the divides, the year check and the day
// carry of an advance, the commit, the weekday and the result handshake
// ----------------------------------------------------------------------------
module cca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    input  logic           i_out_ready,
    input  cca_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output cca_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,
        S_FIX    = 8'b0000_0100,
        S_YCHK   = 8'b0000_1000,
        S_DAY    = 8'b0001_0000,
        S_COMMIT = 8'b0010_0000,
        S_WEEK   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    cca_pkg::t_sel  r_sel;
    cca_pkg::t_sel  n_sel;
    logic           r_out_valid;
    logic           n_out_valid;

    // next state and command
    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        o_cmd.op  = cca_pkg::OP_NONE;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = cca_pkg::OP_LOAD;
                    n_sel    = i_in_kind ? cca_pkg::SEL_SEC : cca_pkg::SEL_YEAR;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = cca_pkg::OP_MUL;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = cca_pkg::OP_FIX;
                case (r_sel)
                    cca_pkg::SEL_SEC: begin
                        n_sel   = cca_pkg::SEL_MIN;
                        n_state = S_MUL;
                    end
                    cca_pkg::SEL_MIN: begin
                        n_sel   = cca_pkg::SEL_HOUR;
                        n_state = S_MUL;
                    end
                    cca_pkg::SEL_HOUR: begin
                        n_sel   = cca_pkg::SEL_MON;
                        n_state = S_MUL;
                    end
                    cca_pkg::SEL_MON: begin
                        n_state = S_YCHK;
                    end
                    cca_pkg::SEL_YEAR: begin
                        n_state = i_sts.kind ? S_DAY : S_COMMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_YCHK: begin
                o_cmd.op = cca_pkg::OP_YCHK;
                if (i_sts.year_ovf) begin
                    n_state = S_COMMIT;
                end else begin
                    n_sel   = cca_pkg::SEL_YEAR;
                    n_state = S_MUL;
                end
            end
            S_DAY: begin
                o_cmd.op = cca_pkg::OP_DAY;
                if (i_sts.day_done || i_sts.err_flag) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.op = cca_pkg::OP_COMMIT;
                n_state  = S_WEEK;
            end
            S_WEEK: begin
                o_cmd.op = cca_pkg::OP_WEEK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = cca_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = (r_out_valid && !i_out_ready) || (o_cmd.op == cca_pkg::OP_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= cca_pkg::SEL_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/calendar_clock_advance_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_advance_core - gregorian calendar clock with weekday
// Input channel (i_in_valid / o_in_ready / i_in_data): a request of kind 0
// loads an absolute date and time, kind 1 adds deltas to every field.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
// request with the date and time, weekday, leap flag and error code.
// One request is in work at a time. A set divides the year modulo 400
// and then commits; an advance runs four field divides on the shared
// constant divider (seconds, minutes, hours, months), a year check, the
// year modulo 400 divide and the day carry loop, one month per cycle,
// before its commit. An advance whose year already passes the largest
// year after the month carry goes from the year check straight to the
// commit. Every request then computes the weekday and writes the result.
// The result register frees the input side: a new request is taken while
// a result still waits, and only the result stage of that request holds
// until the receiver takes the earlier one.
// Reset (synchronous, active low) sets 0001-01-01 00:00:00 and empties
// the result register.
// ----------------------------------------------------------------------------
module calendar_clock_advance_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cca_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cca_pkg::t_out  o_out_data
);

    cca_pkg::t_cmd cmd;
    cca_pkg::t_sts sts;

    cca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_data.kind),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cca_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

`ifndef NO_ASSERTIONS
    // an accepted request makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after a request was taken");

    // a new result appears only at the end of a request in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised without a request in work");

    // a shown result holds a legal calendar value
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.weekday <= 3'd6) && (o_out_data.cur_month <= 4'd11)
                        && (o_out_data.cur_year != 16'd0) && (o_out_data.error != 2'd3))
        else $error("result outside the calendar range");
`endif

endmodule

>>> verif/cca_tb_pkg.sv
// ----------------------------------------------------------------------------
// cca_tb_pkg - calendar clock advance verification helpers
// request kinds and the gregorian month length shared by the stimulus
// and the checker
// ----------------------------------------------------------------------------
package cca_tb_pkg;

    // request kinds
    typedef enum logic {
        KIND_SET     = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    // gregorian leap rule
    function automatic bit leap_of_year(input int unsigned y);
        return (y % cca_pkg::LEAP_STEP == 0) &&
               ((y % cca_pkg::CENTURY != 0) || (y % cca_pkg::YEAR_CYCLE == 0));
    endfunction

    // days in zero-based month m of year y
    function automatic int unsigned days_of_month(input int unsigned m, input int unsigned y);
        int unsigned len;
        if (m == cca_pkg::MON_FEB) begin
            len = leap_of_year(y) ? cca_pkg::DAYS_FEB_LEAP : cca_pkg::DAYS_FEB;
        end else if (m == cca_pkg::MON_APR || m == cca_pkg::MON_JUN ||
                     m == cca_pkg::MON_SEP || m == cca_pkg::MON_NOV) begin
            len = cca_pkg::DAYS_SHORT;
        end else begin
            len = cca_pkg::DAYS_LONG;
        end
        return len;
    endfunction

endpackage

>>> verif/calendar_clock_checker.sv
// ----------------------------------------------------------------------------
// calendar_clock_checker - result checker for the calendar clock core
// Watches both channels. Every accepted request is run through a local
// calendar model that keeps its own date and time; the predicted result
// is queued and compared field by field with the next accepted result.
// ----------------------------------------------------------------------------
module calendar_clock_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  cca_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  cca_pkg::t_out i_out_data,
    output int            o_pending,
    output int            o_fail_count
);

    // model copy of the clock
    logic [15:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;

    cca_pkg::t_out expected_dates[$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // weekday by the gauss formula, 0 is sunday
    function automatic logic [2:0] day_of_week(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned p;
        int unsigned jan1;
        int unsigned diy;
        p    = y - 1;
        jan1 = (1 + 5 * (p % cca_pkg::LEAP_STEP) + 4 * (p % cca_pkg::CENTURY)
                + 6 * (p % cca_pkg::YEAR_CYCLE)) % cca_pkg::DAYS_PER_WEEK;
        diy  = d;
        for (int unsigned i = 0; i < m && i < cca_pkg::MON_PER_YEAR; i++) begin
            diy += cca_tb_pkg::days_of_month(i, y);
        end
        return 3'((diy % cca_pkg::DAYS_PER_WEEK + jan1) % cca_pkg::DAYS_PER_WEEK);
    endfunction

    // apply one request to the model clock and build its result
    function automatic cca_pkg::t_out predict_clock(input cca_pkg::t_in r);
        int unsigned   s, n, h, d, m, y, len;
        cca_pkg::t_err err;
        cca_pkg::t_out res;
        err = cca_pkg::ERR_OK;
        if (r.kind == cca_tb_pkg::KIND_SET) begin
            if (r.year_value == 0 || r.month_value > cca_pkg::MON_PER_YEAR - 1 ||
                r.day_value >= cca_tb_pkg::days_of_month(r.month_value, r.year_value) ||
                r.hour_value > cca_pkg::HOUR_PER_DAY - 1 ||
                r.minute_value > cca_pkg::MIN_PER_HOUR - 1 ||
                r.second_value > cca_pkg::SEC_PER_MIN - 1) begin
                err = cca_pkg::ERR_SET;
            end else begin
                cal_year   = r.year_value;
                cal_month  = 4'(r.month_value);
                cal_day    = 5'(r.day_value);
                cal_hour   = 5'(r.hour_value);
                cal_minute = 6'(r.minute_value);
                cal_second = 6'(r.second_value);
            end
        end else begin
            s = cal_second + r.second_value;
            n = cal_minute + r.minute_value + s / cca_pkg::SEC_PER_MIN;
            h = cal_hour + r.hour_value + n / cca_pkg::MIN_PER_HOUR;
            d = cal_day + r.day_value + h / cca_pkg::HOUR_PER_DAY;
            m = cal_month + r.month_value;
            y = cal_year + r.year_value + m / cca_pkg::MON_PER_YEAR;
            s = s % cca_pkg::SEC_PER_MIN;
            n = n % cca_pkg::MIN_PER_HOUR;
            h = h % cca_pkg::HOUR_PER_DAY;
            m = m % cca_pkg::MON_PER_YEAR;
            if (y > cca_pkg::YEAR_MAX) begin
                err = cca_pkg::ERR_YEAR;
            end else begin
                // walk the day count through month lengths
                len = cca_tb_pkg::days_of_month(m, y);
                while (d >= len && err == cca_pkg::ERR_OK) begin
                    d = d - len;
                    m = m + 1;
                    if (m >= cca_pkg::MON_PER_YEAR) begin
                        m = 0;
                        y = y + 1;
                        if (y > cca_pkg::YEAR_MAX) begin
                            err = cca_pkg::ERR_YEAR;
                        end
                    end
                    len = cca_tb_pkg::days_of_month(m, y);
                end
            end
            if (err == cca_pkg::ERR_OK) begin
                cal_year   = 16'(y);
                cal_month  = 4'(m);
                cal_day    = 5'(d);
                cal_hour   = 5'(h);
                cal_minute = 6'(n);
                cal_second = 6'(s);
            end
        end
        res.cur_year   = cal_year;
        res.cur_month  = cal_month;
        res.cur_day    = cal_day;
        res.cur_hour   = cal_hour;
        res.cur_minute = cal_minute;
        res.cur_second = cal_second;
        res.weekday    = day_of_week(cal_year, cal_month, cal_day);
        res.leap       = cca_tb_pkg::leap_of_year(cal_year);
        res.error      = err;
        return res;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_fail_count++;
    endtask

    task automatic compare_result(input cca_pkg::t_out got, input cca_pkg::t_out want);
        if (got.cur_year !== want.cur_year)
            report_mismatch("cur_year", got.cur_year, want.cur_year);
        if (got.cur_month !== want.cur_month)
            report_mismatch("cur_month", got.cur_month, want.cur_month);
        if (got.cur_day !== want.cur_day)
            report_mismatch("cur_day", got.cur_day, want.cur_day);
        if (got.cur_hour !== want.cur_hour)
            report_mismatch("cur_hour", got.cur_hour, want.cur_hour);
        if (got.cur_minute !== want.cur_minute)
            report_mismatch("cur_minute", got.cur_minute, want.cur_minute);
        if (got.cur_second !== want.cur_second)
            report_mismatch("cur_second", got.cur_second, want.cur_second);
        if (got.weekday !== want.weekday)
            report_mismatch("weekday", got.weekday, want.weekday);
        if (got.leap !== want.leap)
            report_mismatch("leap", got.leap, want.leap);
        if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
    endtask

    // channel monitor: results are matched before new requests are queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_year   = 16'd1;
            cal_month  = '0;
            cal_day    = '0;
            cal_hour   = '0;
            cal_minute = '0;
            cal_second = '0;
            expected_dates.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result without request, cur_year", i_out_data.cur_year, 0);
                end else begin
                    compare_result(i_out_data, expected_dates.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_dates.push_back(predict_clock(i_in_data));
            end
        end
        o_pending <= expected_dates.size();
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - calendar clock advance core testbench
// Drives directed and random set and advance requests with random idling
// on both channels; a checker beside the core predicts and compares every
// result. A watchdog ends the run if the channels stop moving.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int TAIL_CYCLES     = 40;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    cca_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready;
    cca_pkg::t_out out_data;

    int pending;
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    calendar_clock_advance_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    calendar_clock_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic cca_pkg::t_in make_request(input cca_tb_pkg::t_kind kind,
                                                  input int unsigned y,
                                                  input int unsigned m, input int unsigned d,
                                                  input int unsigned h, input int unsigned n,
                                                  input int unsigned s);
        cca_pkg::t_in r;
        r.kind         = kind;
        r.year_value   = 16'(y);
        r.month_value  = 8'(m);
        r.day_value    = 16'(d);
        r.hour_value   = 8'(h);
        r.minute_value = 8'(n);
        r.second_value = 16'(s);
        return r;
    endfunction

    // set request: mostly a valid date, sometimes any field values
    function automatic cca_pkg::t_in random_set();
        int unsigned y, m, sel;
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            if (sel < 40) begin
                y = $urandom_range(1, 3000);
            end else if (sel < 70) begin
                y = $urandom_range(1, 65535);
            end else begin
                y = $urandom_range(65500, 65535);
            end
            m = $urandom_range(0, cca_pkg::MON_PER_YEAR - 1);
            return make_request(cca_tb_pkg::KIND_SET, y, m,
                                $urandom_range(0, cca_tb_pkg::days_of_month(m, y) - 1),
                                $urandom_range(0, cca_pkg::HOUR_PER_DAY - 1),
                                $urandom_range(0, cca_pkg::MIN_PER_HOUR - 1),
                                $urandom_range(0, cca_pkg::SEC_PER_MIN - 1));
        end
        return make_request(cca_tb_pkg::KIND_SET, $urandom_range(0, 65535),
                            $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 65535));
    endfunction

    // advance request: mostly small ticks, with occasional full-range deltas
    function automatic cca_pkg::t_in random_advance();
        int unsigned y, m, d, h, n, s, sel;
        s = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 150) : $urandom_range(0, 65535);
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        h = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(0, 255);
        m = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            d = $urandom_range(0, 40);
        end else if (sel < 96) begin
            d = $urandom_range(0, 800);
        end else begin
            d = $urandom_range(0, 65535);
        end
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            y = 0;
        end else if (sel < 95) begin
            y = $urandom_range(0, 20);
        end else begin
            y = $urandom_range(0, 65535);
        end
        return make_request(cca_tb_pkg::KIND_ADVANCE, y, m, d, h, n, s);
    endfunction

    // hold one request until the core takes it, with random gaps ahead
    task automatic send_request(input cca_pkg::t_in r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
    endtask

    initial begin
        send_idle_pct = 16;
        recv_idle_pct = 65;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, leap day, carries, every range error, overflow
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2000, 1, 28, 23, 59, 59));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 1));
        send_request(make_request(cca_tb_pkg::KIND_SET, 1900, 1, 28, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 0, 0, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2024, 12, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2024, 3, 30, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2024, 0, 0, 24, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2024, 0, 0, 0, 60, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2024, 0, 0, 0, 0, 60));
        send_request(make_request(cca_tb_pkg::KIND_SET, 65535, 255, 65535, 255, 255, 65535));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2023, 11, 30, 23, 59, 59));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 1));
        send_request(make_request(cca_tb_pkg::KIND_SET, 2400, 0, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 365, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 65535, 11, 30, 23, 59, 59));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 1));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 1, 0, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 65534, 11, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 0, 40, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_SET, 1, 0, 0, 0, 0, 0));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 65535, 255, 65535, 255, 255,
                                  65535));
        send_request(make_request(cca_tb_pkg::KIND_ADVANCE, 0, 255, 65535, 255, 255, 65535));

        // random part in three idling phases
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 16;
            end else if (i == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 15) begin
                send_request(random_set());
            end else begin
                send_request(random_advance());
            end
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        // drain and settle
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
